### rtl/core/deqpp_pkg.sv
package deqpp_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_RESULTS    = 32;

    localparam int FUNC_W   = 3;
    localparam int ITEM_W   = 32;
    localparam int PIVOT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PARTITION  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READOUT    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_OUT,
        S_PV_LATCH,
        S_PART_RD,
        S_PART_CMP,
        S_PART_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FIX_RD,
        S_FIX_W1,
        S_FIX_W2,
        S_RO_OUT
    } t_state;

endpackage

### rtl/core/deque_with_pivot_partition.sv
// Bounded deque of signed values held in one circular memory (two read
// ports, one write port, registered read data).
// Command channel: i_func, i_item_value and i_pivot_index are taken at a rising
// edge where start is high and busy is low. Results leave on o_status,
// o_result_value and o_last, each valid for exactly one cycle while o_strobe
// is high; o_last marks the final result of a command.
// Sequence of each command, from the accepting edge to the strobe:
//   push, error answers, unused codes: result in the cycle after acceptance, busy stays low (1 per cycle).
//   pop: busy in S_POP_OUT for the memory read, then the value is registered out.
//   readout of n elements: one result per cycle once the first read is back,
//   capped at MAX_RESULTS.
//   partition of n elements: pivot read, then per element the Lomuto walk
//   (read, compare, up to two single-port writes), then per element the
//   search for the pivot value (read, compare), and the closing swap (read,
//   two writes). The single write port splits the writes into separate steps.
// Reset empties the deque at once; memory contents are left as they are.
// The receiver cannot stall: every result is on the ports for one cycle only.
module deque_with_pivot_partition #(
    parameter int DEPTH      = deqpp_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deqpp_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deqpp_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [deqpp_pkg::ITEM_W-1:0] i_item_value,
    input  logic [deqpp_pkg::PIVOT_W-1:0]       i_pivot_index,
    output logic                                o_strobe,
    output logic [deqpp_pkg::STATUS_W-1:0]      o_status,
    output logic signed [deqpp_pkg::ITEM_W-1:0] o_result_value,
    output logic                                o_last
);
    import deqpp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    t_state                r_state, n_state;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_z, n_z;
    logic [CW-1:0]         r_region, n_region;
    logic [CW-1:0]         r_lim, n_lim;
    logic [DATA_WIDTH-1:0] r_pivot, n_pivot;
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;
    logic                  r_strobe, n_strobe;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [ITEM_W-1:0]     r_value, n_value;
    logic                  r_last, n_last;

    logic                  rd_en, we;
    logic [AW-1:0]         addr_a, addr_b, waddr;
    logic [DATA_WIDTH-1:0] wdata;

    logic                  less, equal, z_last, ro_last, is_empty, is_full, pidx_bad;
    logic [CW-1:0]         z_next;
    logic [AW-1:0]         front_dec, front_inc;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                           input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(front) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [ITEM_W-1:0] sext(input logic [DATA_WIDTH-1:0] d);
        logic signed [DATA_WIDTH-1:0] s;
        s = d;
        return ITEM_W'(s);
    endfunction

    assign busy     = (r_state != S_IDLE);
    assign less     = $signed(r_rd_a) < $signed(r_pivot);
    assign equal    = (r_rd_a == r_pivot);
    assign z_next   = r_z + CW'(1);
    assign z_last   = (z_next == r_count);
    assign ro_last  = (z_next == r_lim);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == CW'(DEPTH));
    assign pidx_bad = (32'(i_pivot_index) >= 32'(r_count));
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_func)
                        FN_POP_FRONT, FN_POP_BACK: begin
                            if (!is_empty) n_state = S_POP_OUT;
                        end
                        FN_PARTITION: begin
                            if (!is_empty && !pidx_bad) n_state = S_PV_LATCH;
                        end
                        FN_READOUT: begin
                            if (!is_empty) n_state = S_RO_OUT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_POP_OUT:  n_state = S_IDLE;
            S_PV_LATCH: n_state = S_PART_CMP;
            S_PART_RD:  n_state = S_PART_CMP;
            S_PART_CMP: begin
                if (less) n_state = S_PART_WR;
                else if (z_last) n_state = S_SCAN_RD;
                else n_state = S_PART_RD;
            end
            S_PART_WR:  n_state = z_last ? S_SCAN_RD : S_PART_RD;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (equal) n_state = (r_region < r_count) ? S_FIX_RD : S_IDLE;
                else if (z_last) n_state = S_IDLE;
                else n_state = S_SCAN_RD;
            end
            S_FIX_RD:   n_state = S_FIX_W1;
            S_FIX_W1:   n_state = S_FIX_W2;
            S_FIX_W2:   n_state = S_IDLE;
            S_RO_OUT:   n_state = ro_last ? S_IDLE : S_RO_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_z      = r_z;
        n_region = r_region;
        n_lim    = r_lim;
        n_pivot  = r_pivot;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_value  = '0;
        n_last   = 1'b1;
        rd_en    = 1'b0;
        addr_a   = '0;
        addr_b   = '0;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_func)
                        FN_PUSH_FRONT, FN_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                wdata   = i_item_value[DATA_WIDTH-1:0];
                                n_count = r_count + CW'(1);
                                if (i_func == FN_PUSH_FRONT) begin
                                    waddr   = front_dec;
                                    n_front = front_dec;
                                end else begin
                                    waddr = slot(r_front, r_count);
                                end
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - CW'(1);
                                if (i_func == FN_POP_FRONT) begin
                                    addr_a  = r_front;
                                    n_front = front_inc;
                                end else begin
                                    addr_a = slot(r_front, r_count - CW'(1));
                                end
                            end
                        end
                        FN_PARTITION: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (pidx_bad) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                rd_en    = 1'b1;
                                addr_a   = slot(r_front, CW'(i_pivot_index));
                                n_z      = '0;
                                n_region = '0;
                            end
                        end
                        FN_READOUT: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                rd_en  = 1'b1;
                                addr_a = r_front;
                                n_z    = '0;
                                n_lim  = (32'(r_count) > MAX_RESULTS) ?
                                         CW'(MAX_RESULTS) : r_count;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_POP_OUT: begin
                n_strobe = 1'b1;
                n_value  = sext(r_rd_a);
            end
            S_PV_LATCH: begin
                // pivot arrives; fetch the first element for the walk
                n_pivot = r_rd_a;
                rd_en   = 1'b1;
                addr_a  = slot(r_front, r_z);
                addr_b  = slot(r_front, r_region);
            end
            S_PART_RD: begin
                rd_en  = 1'b1;
                addr_a = slot(r_front, r_z);
                addr_b = slot(r_front, r_region);
            end
            S_PART_CMP: begin
                if (less) begin
                    we    = 1'b1;
                    waddr = slot(r_front, r_region);
                    wdata = r_rd_a;
                end else begin
                    n_z = z_last ? '0 : z_next;
                end
            end
            S_PART_WR: begin
                we       = 1'b1;
                waddr    = slot(r_front, r_z);
                wdata    = r_rd_b;
                n_region = r_region + CW'(1);
                n_z      = z_last ? '0 : z_next;
            end
            S_SCAN_RD: begin
                rd_en  = 1'b1;
                addr_a = slot(r_front, r_z);
            end
            S_SCAN_CMP: begin
                if (equal) begin
                    if (r_region >= r_count) begin
                        n_strobe = 1'b1;
                        n_value  = ITEM_W'(r_region);
                    end
                end else if (z_last) begin
                    // no pivot-valued element left: finish without the swap
                    n_strobe = 1'b1;
                    n_value  = ITEM_W'(r_region);
                end else begin
                    n_z = z_next;
                end
            end
            S_FIX_RD: begin
                rd_en  = 1'b1;
                addr_a = slot(r_front, r_region);
                addr_b = slot(r_front, r_z);
            end
            S_FIX_W1: begin
                we    = 1'b1;
                waddr = slot(r_front, r_region);
                wdata = r_rd_b;
            end
            S_FIX_W2: begin
                we       = 1'b1;
                waddr    = slot(r_front, r_z);
                wdata    = r_rd_a;
                n_strobe = 1'b1;
                n_value  = ITEM_W'(r_region);
            end
            S_RO_OUT: begin
                n_strobe = 1'b1;
                n_value  = sext(r_rd_a);
                n_last   = ro_last;
                if (!ro_last) begin
                    // keep one read in flight to stream a result per cycle
                    n_z    = z_next;
                    rd_en  = 1'b1;
                    addr_a = slot(r_front, z_next);
                end
            end
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_a <= mem[addr_a];
            r_rd_b <= mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z      <= n_z;
        r_region <= n_region;
        r_lim    <= n_lim;
        r_pivot  <= n_pivot;
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_last         = r_last;

endmodule
